FILE: src/rbrf_pkg.sv
// Shared types and codes for the receive-byte ring FIFO with skip.
// Used by the store, the sequencer, the top level and the testbench; depends on nothing.
package rbrf_pkg;

   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 6;
   localparam int ACTION_W = 2;

   // Request kinds carried in the request tuser field.
   localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_POP  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SKIP = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP_WAIT,
      ST_SKIP_CMP,
      ST_RESP
   } state_type;

   // One response, packed from the lowest bit up as byte, count, dropped, skip done.
   typedef struct packed {
      logic               skip_done;
      logic               dropped;
      logic [COUNT_W-1:0] count_before;
      logic [BYTE_W-1:0]  byte_out;
   } rsp_type;

endpackage

FILE: src/rbrf_store.sv
// Byte store of the ring FIFO: one write port and one read port with registered data.
// Depends on rbrf_pkg for the byte width.
module rbrf_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [rbrf_pkg::BYTE_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [rbrf_pkg::BYTE_W-1:0] rd_data
);
   import rbrf_pkg::*;

   logic [BYTE_W-1:0] store_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data appears in the cycle after the address.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/rbrf_ctrl.sv
// Sequencer of the ring FIFO: holds the indexes and the skip state, and drives the
// store and a single byte comparator through a sequence of states per request. Uses rbrf_pkg.
module rbrf_ctrl #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rbrf_pkg::ACTION_W-1:0] req_action,
   input  logic [rbrf_pkg::BYTE_W-1:0]   req_byte,
   input  logic                          out_free,
   output logic                          rsp_load,
   output rbrf_pkg::rsp_type             rsp_result,
   output logic                          mem_wr_en,
   output logic [AW-1:0]                 mem_wr_addr,
   output logic [rbrf_pkg::BYTE_W-1:0]   mem_wr_data,
   output logic                          mem_rd_en,
   output logic [AW-1:0]                 mem_rd_addr,
   input  logic [rbrf_pkg::BYTE_W-1:0]   mem_rd_data
);
   import rbrf_pkg::*;

   localparam logic [AW:0]   SLOTS    = (AW+1)'(DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   state_type           state_ff, state_in;
   logic [ACTION_W-1:0] action_ff, action_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic [AW-1:0]       wptr_ff, wptr_in;
   logic [AW-1:0]       rptr_ff, rptr_in;
   logic                pending_ff, pending_in;
   logic [BYTE_W-1:0]   target_ff, target_in;
   rsp_type             result_ff, result_in;

   logic [AW-1:0]     wptr_next;
   logic [AW-1:0]     rptr_next;
   logic [AW:0]       occ;
   logic              empty;
   logic              full;
   logic [BYTE_W-1:0] cmp_a;
   logic              match;

   // Ring index advance, wrapping at the last slot.
   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   assign wptr_next = next_slot(wptr_ff);
   assign rptr_next = next_slot(rptr_ff);
   assign empty     = (wptr_ff == rptr_ff);
   assign full      = (wptr_next == rptr_ff);

   // Occupancy before a pop, modulo the ring size.
   assign occ = (wptr_ff >= rptr_ff) ? ({1'b0, wptr_ff} - {1'b0, rptr_ff})
                                     : (SLOTS + {1'b0, wptr_ff} - {1'b0, rptr_ff});

   // The one comparator: stored bytes during a skip, the pushed byte otherwise.
   assign cmp_a = (state_ff == ST_SKIP_CMP) ? mem_rd_data : byte_ff;
   assign match = (cmp_a == target_ff);

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wptr_ff    <= '0;
         rptr_ff    <= '0;
         pending_ff <= 1'b0;
         target_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         wptr_ff    <= wptr_in;
         rptr_ff    <= rptr_in;
         pending_ff <= pending_in;
         target_ff  <= target_in;
      end
   end

   // Request and result payload registers.
   always_ff @(posedge clock) begin
      action_ff <= action_in;
      byte_ff   <= byte_in;
      result_ff <= result_in;
   end

   // Next state and outputs.
   always_comb begin
      state_in    = state_ff;
      action_in   = action_ff;
      byte_in     = byte_ff;
      wptr_in     = wptr_ff;
      rptr_in     = rptr_ff;
      pending_in  = pending_ff;
      target_in   = target_ff;
      result_in   = result_ff;
      req_ready   = 1'b0;
      rsp_load    = 1'b0;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = rptr_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               action_in = req_action;
               byte_in   = req_byte;
               state_in  = ST_EXEC;
            end
         end

         ST_EXEC: begin
            result_in = '0;
            state_in  = ST_RESP;
            case (action_ff)
               ACT_PUSH: begin
                  if (pending_ff) begin
                     // A pending skip swallows the byte, and ends on its target.
                     result_in.dropped = 1'b1;
                     if (match) begin
                        pending_in          = 1'b0;
                        result_in.skip_done = 1'b1;
                     end
                  end else if (full) begin
                     result_in.dropped = 1'b1;
                  end else begin
                     mem_wr_en = 1'b1;
                     wptr_in   = wptr_next;
                  end
               end
               ACT_POP: begin
                  if (!pending_ff && !empty) begin
                     mem_rd_en              = 1'b1;
                     result_in.count_before = COUNT_W'(occ);
                     state_in               = ST_POP_WAIT;
                  end
               end
               ACT_SKIP: begin
                  target_in = byte_ff;
                  if (empty) begin
                     pending_in = 1'b1;
                  end else begin
                     mem_rd_en = 1'b1;
                     state_in  = ST_SKIP_CMP;
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end

         ST_POP_WAIT: begin
            result_in.byte_out = mem_rd_data;
            rptr_in            = rptr_next;
            state_in           = ST_RESP;
         end

         ST_SKIP_CMP: begin
            // Each stored byte is discarded as it is compared.
            rptr_in = rptr_next;
            if (match) begin
               pending_in          = 1'b0;
               result_in.skip_done = 1'b1;
               state_in            = ST_RESP;
            end else if (rptr_next == wptr_ff) begin
               pending_in = 1'b1;
               state_in   = ST_RESP;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rptr_next;
            end
         end

         ST_RESP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign mem_wr_addr = wptr_ff;
   assign mem_wr_data = byte_ff;
   assign rsp_result  = result_ff;

endmodule

FILE: src/rx_byte_ring_fifo_skip.sv
// Top level of the receive-byte ring FIFO with skip-to-target.
// Instantiates rbrf_store and rbrf_ctrl, and holds the response register; uses rbrf_pkg.
//
//   channel   direction   handshake              payload
//   req       in          req_tvalid/req_tready  tdata byte_in, tuser action
//   rsp       out         rsp_tvalid/rsp_tready  tdata byte, count; tuser flags
//
// A push goes from idle through the execute and response states, a pop also through
// pop-wait, and a skip through a compare step for each stored byte it examines; the sequencer walks the store
// through its single read port, one byte a cycle. Reset empties the ring and clears
// any pending skip; the store itself is not cleared. A response waiting in the output
// register does not stop the next request from being accepted; the request after
// that waits until the response is taken.
module rx_byte_ring_fifo_skip #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] byte_out, [13:8] count_before, [15:14] zero
   output logic [1:0]  rsp_tuser    // [0] dropped, [1] skip_done
);
   import rbrf_pkg::*;

   localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;

   logic              out_free;
   logic              rsp_load;
   rsp_type           ctrl_result;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [BYTE_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [BYTE_W-1:0] mem_rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;

   rbrf_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_action  (req_tuser),
      .req_byte    (req_tdata),
      .out_free    (out_free),
      .rsp_load    (rsp_load),
      .rsp_result  (ctrl_result),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   rbrf_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Output register: free when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= ctrl_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff.count_before, rsp_data_ff.byte_out};
   assign rsp_tuser  = {rsp_data_ff.skip_done, rsp_data_ff.dropped};

endmodule

FILE: src/rbrf_check.sv
// Port-level checker for the receive-byte ring FIFO, bound to the top level.
// Depends only on the top level's ports.
module rbrf_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Once a request is taken the block is busy for at least the next cycle.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted in back-to-back cycles");

   // A dropped push or a finished skip never carries popped data.
   a_flags_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != 2'b00) |-> rsp_tdata == 16'd0)
      else $error("flagged response carries pop data");

   // No response is shown straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind rx_byte_ring_fifo_skip rbrf_check u_rbrf_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/sv/rx_byte_ring_fifo_skip_test.sv
// Self-checking testbench for the receive-byte ring FIFO with skip-to-target.
// Drives push, pop and skip requests, predicts every response and compares them.
// Depends on rbrf_pkg and rx_byte_ring_fifo_skip.
`timescale 1ns / 100ps

module rx_byte_ring_fifo_skip_test;
   import rbrf_pkg::*;

   localparam int RING_DEPTH = 64;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 100;
   localparam int TOTAL_REQUESTS = 1550;
   // Action three is outside the defined set; the block must leave its state alone.
   localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata = 8'd0;   // [7:0] byte_in
   logic [1:0]        req_tuser = 2'd0;   // [1:0] action
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [15:0]       rsp_tdata;          // [7:0] byte_out, [13:8] count_before, [15:14] zero
   logic [1:0]        rsp_tuser;          // [0] dropped, [1] skip_done

   // Predicted state of the ring.
   logic [BYTE_W-1:0]  ring_bytes [RING_DEPTH];
   logic [COUNT_W-1:0] wr_ptr = '0;
   logic [COUNT_W-1:0] rd_ptr = '0;
   logic               skip_armed = 1'b0;
   logic [BYTE_W-1:0]  skip_byte = '0;

   rsp_type queued_responses [$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      requests_sent = 0;
   bit      sender_steady = 1'b0;
   bit      receiver_steady = 1'b0;
   int      hold_request = 0;
   int      hold_left = 0;
   int      stall_left = 0;

   rx_byte_ring_fifo_skip #(
      .DEPTH(RING_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Applies one request to the predicted ring and returns the response it owes.
   function automatic rsp_type fifo_apply(input logic [1:0] act, input logic [7:0] b);
      rsp_type r;
      logic    hit;
      r = '0;
      hit = 1'b0;
      case (act)
         ACT_PUSH: begin
            if (skip_armed) begin
               r.dropped = 1'b1;
               if (b == skip_byte) begin
                  skip_armed = 1'b0;
                  r.skip_done = 1'b1;
               end
            end else if (COUNT_W'(wr_ptr + 1'b1) == rd_ptr) begin
               r.dropped = 1'b1;
            end else begin
               ring_bytes[wr_ptr] = b;
               wr_ptr = wr_ptr + 1'b1;
            end
         end
         ACT_POP: begin
            if (!skip_armed && wr_ptr != rd_ptr) begin
               r.count_before = wr_ptr - rd_ptr;
               r.byte_out = ring_bytes[rd_ptr];
               rd_ptr = rd_ptr + 1'b1;
            end
         end
         ACT_SKIP: begin
            skip_byte = b;
            while (wr_ptr != rd_ptr && !hit) begin
               hit = (ring_bytes[rd_ptr] == b);
               rd_ptr = rd_ptr + 1'b1;
            end
            skip_armed = !hit;
            r.skip_done = hit;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic int ring_fill();
      return int'(COUNT_W'(wr_ptr - rd_ptr));
   endfunction

   // A byte currently held in the predicted ring; only called when it is not empty.
   function automatic logic [7:0] stored_byte();
      logic [COUNT_W-1:0] idx;
      idx = rd_ptr + COUNT_W'($urandom_range(0, ring_fill() - 1));
      return ring_bytes[idx];
   endfunction

   // Half the values come from a small set so that skips often find their target.
   function automatic logic [7:0] random_byte();
      if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 7));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] byte_except(input logic [7:0] avoid);
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == avoid) ? ~avoid : b;
   endfunction

   // Mostly short pauses, now and then a long one.
   function automatic int stall_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= 40)
         $display("mismatch at cycle %0d: %s got 0x%0h, expected 0x%0h",
                  cycle_count, what, got, want);
   endtask

   // Sends one request and records the response it owes once it is accepted.
   // Called at a rising edge; returns at the edge of acceptance with valid still high.
   task automatic send_request(input logic [1:0] act, input logic [7:0] b);
      int gap;
      gap = (sender_steady || $urandom_range(0, 1) == 0) ? 0 : stall_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      queued_responses.push_back(fifo_apply(act, b));
      requests_sent++;
   endtask

   // Stops offering requests and waits until every owed response has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (queued_responses.size() != 0) @(posedge clock);
   endtask

   // Response side: random stalls, and a long hold when a test asks for one.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!receiver_steady && $urandom_range(0, 9) == 0) begin
         stall_left = stall_length() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compares each accepted response with the oldest one owed.
   always @(posedge clock) begin : check_response
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (queued_responses.size() == 0) begin
            report_mismatch("response with none owed", int'({rsp_tuser, rsp_tdata}), 0);
         end else begin
            want = queued_responses.pop_front();
            if (rsp_tdata[7:0] !== want.byte_out)
               report_mismatch("byte_out", int'(rsp_tdata[7:0]), int'(want.byte_out));
            if (rsp_tdata[13:8] !== want.count_before)
               report_mismatch("count_before", int'(rsp_tdata[13:8]),
                               int'(want.count_before));
            if (rsp_tdata[15:14] !== 2'b00)
               report_mismatch("tdata padding", int'(rsp_tdata[15:14]), 0);
            if (rsp_tuser[0] !== want.dropped)
               report_mismatch("dropped", int'(rsp_tuser[0]), int'(want.dropped));
            if (rsp_tuser[1] !== want.skip_done)
               report_mismatch("skip_done", int'(rsp_tuser[1]), int'(want.skip_done));
         end
      end
   end

   // Empty ring, pending skips, target replacement and a skip that finds its target.
   task automatic test_directed_cases();
      send_request(ACT_POP, 8'hFF);    // pop on an empty ring
      send_request(ACT_SKIP, 8'hA5);   // skip on an empty ring goes pending
      send_request(ACT_PUSH, 8'h00);   // dropped while pending
      send_request(ACT_POP, 8'h00);    // pop reports empty while pending
      send_request(ACT_SKIP, 8'hFF);   // new target replaces the pending one
      send_request(ACT_PUSH, 8'hA5);   // old target no longer ends the skip
      send_request(ACT_PUSH, 8'hFF);   // target arrives: dropped and done
      send_request(ACT_NONE, 8'hFF);
      send_request(ACT_PUSH, 8'h00);
      send_request(ACT_PUSH, 8'hFF);
      send_request(ACT_PUSH, 8'h5A);
      send_request(ACT_PUSH, 8'h81);
      send_request(ACT_POP, 8'h00);
      send_request(ACT_SKIP, 8'h5A);   // removes two bytes, one remains
      send_request(ACT_POP, 8'h00);
      send_request(ACT_POP, 8'h00);
      wait_drained();
   endtask

   // Fills the ring to its limit, then walks full-length skips that miss and hit.
   task automatic test_full_ring();
      logic [7:0] absent;
      int         n;
      absent = 8'($urandom_range(0, 255));
      for (n = 0; n < RING_DEPTH + 1; n++) send_request(ACT_PUSH, byte_except(absent));
      send_request(ACT_POP, 8'($urandom_range(0, 255)));
      send_request(ACT_PUSH, byte_except(absent));
      send_request(ACT_SKIP, absent);
      send_request(ACT_PUSH, absent);
      for (n = 0; n < RING_DEPTH - 2; n++) send_request(ACT_PUSH, byte_except(absent));
      send_request(ACT_PUSH, absent);
      send_request(ACT_SKIP, absent);
      send_request(ACT_POP, 8'($urandom_range(0, 255)));
      wait_drained();
   endtask

   // Holds the response side off for a long stretch so that the request side stalls.
   task automatic test_output_backpressure();
      int n;
      sender_steady = 1'b1;
      hold_request = 200;
      for (n = 0; n < 6; n++) begin
         send_request(ACT_PUSH, random_byte());
         send_request(ACT_POP, random_byte());
      end
      sender_steady = 1'b0;
      wait_drained();
   endtask

   // Random traffic in phases that fill, drain or balance the ring.
   task automatic test_random_traffic(input int total);
      int         mode;
      int         pick;
      int         push_weight;
      logic [1:0] act;
      logic [7:0] b;
      mode = 2;
      while (requests_sent < total) begin
         if (requests_sent % 64 == 0) begin
            mode = $urandom_range(0, 2);
            sender_steady = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
         end
         push_weight = (mode == 0) ? 70 : (mode == 1) ? 25 : 45;
         pick = $urandom_range(0, 99);
         if (pick < 1) act = ACT_NONE;
         else if (pick < 9) act = ACT_SKIP;
         else if (pick < 9 + push_weight) act = ACT_PUSH;
         else act = ACT_POP;
         if (act == ACT_PUSH && skip_armed && $urandom_range(0, 3) == 0)
            b = skip_byte;
         else if (act == ACT_SKIP && ring_fill() > 0 && $urandom_range(0, 2) != 0)
            b = stored_byte();
         else
            b = random_byte();
         send_request(act, b);
      end
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_full_ring();
      test_output_backpressure();
      test_random_traffic(TOTAL_REQUESTS);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

FILE: filelist.f
src/rbrf_pkg.sv
src/rbrf_store.sv
src/rbrf_ctrl.sv
src/rx_byte_ring_fifo_skip.sv
src/rbrf_check.sv
tb/sv/rx_byte_ring_fifo_skip_test.sv
